### hw/rtl/pls_pkg.sv
package pls_pkg;

    localparam int FRAMES_MAX = 4096;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_W      = 13;
    localparam int POS_W      = 12;
    localparam int STEP_W     = 24;
    localparam int SEEK_W     = 24;
    localparam int EL_W       = 16;
    localparam int PROD_W     = EL_W + STEP_W + 1;
    localparam int DVD_W      = 24;
    localparam int PW         = 26;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 24;

    localparam logic [1:0] MODE_CLAMP    = 2'd0;
    localparam logic [1:0] MODE_WRAP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FIRST = 3'd1;
    localparam logic [IDX_W-1:0] REG_LAST  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOTAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP  = 3'd4;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [CNT_W-1:0]  first;
        logic signed [CNT_W-1:0]  last;
        logic [CNT_W-1:0]         total;
        logic signed [STEP_W-1:0] step;
    } cfg_t;

    typedef struct packed {
        logic pp_wr;
        logic step_pos;
    } mode_wr_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] rem;
        logic             q_lsb;
    } div_rsp_t;

    typedef struct packed {
        logic [POS_W-1:0] frame;
        logic             frame_new;
        logic             forward;
    } res_t;

endpackage

### hw/rtl/playhead_loop_stepper_top.sv
// Frame playhead with clamp, wrap and ping-pong loop modes. Each word on the
// slave side is either a tick (tuser 0: elapsed time is scaled by the Q8.16
// step, whole frames move the playhead, the fraction is kept) or a seek
// (tuser 1: the frame is set to the non-negative remainder of seek_frame by
// the frame count); each gives one result word. While the frame count is
// zero, any word goes straight to the output state; a tick that needs no
// division passes multiply, add, plan and output; a seek, and a tick that
// leaves the loop in wrap or ping-pong mode, run the shared restoring divider,
// one quotient bit per cycle. One item is in work at a time; the next word is
// taken in the cycle after the result enters the output register, even while
// that result still waits for m_tready. While the output register is still
// full and m_tready is low, a finished result holds in the sequencer and
// s_tready stays low.
module playhead_loop_stepper_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // elapsed[15:0], seek_frame[39:16]
    input  logic                        s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // frame[11:0], frame_new[12], forward[13]
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pls_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pls_pkg::CFG_W-1:0]   cfg_data
);
    import pls_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    mode_wr_t mode_wr;
    div_req_t div_req;
    div_rsp_t div_rsp;
    res_t     res;
    res_t     out_reg;
    logic     out_valid_reg;
    logic     res_valid, res_ready;
    logic     cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_MODE:  cfg_next.mode  = cfg_data[1:0];
                REG_FIRST: cfg_next.first = $signed(cfg_data[CNT_W-1:0]);
                REG_LAST:  cfg_next.last  = $signed(cfg_data[CNT_W-1:0]);
                REG_TOTAL: cfg_next.total = cfg_data[CNT_W-1:0];
                REG_STEP:  cfg_next.step  = $signed(cfg_data[STEP_W-1:0]);
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    // entering ping-pong takes its direction from the step sign
    assign mode_wr.pp_wr    = cfg_wr && (cfg_index == REG_MODE)
                              && (cfg_data[1:0] == MODE_PINGPONG);
    assign mode_wr.step_pos = !cfg_reg.step[STEP_W-1] && (cfg_reg.step != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= MODE_WRAP;
            cfg_reg.first <= '1;
            cfg_reg.last  <= '1;
            cfg_reg.total <= '0;
            cfg_reg.step  <= STEP_W'(1 << FRAC_BITS);
        end
        else
            cfg_reg <= cfg_next;
    end

    pls_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    pls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .mode_wr    (mode_wr),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_elapsed (s_tdata[15:0]),
        .in_seek    ($signed(s_tdata[39:16])),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.forward, out_reg.frame_new, out_reg.frame};

endmodule

### hw/rtl/pls_div.sv
module pls_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pls_pkg::div_req_t req,
    output pls_pkg::div_rsp_t rsp
);
    import pls_pkg::*;

    localparam int STEPS = DVD_W;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int RW    = CNT_W + 1;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             q_reg, q_next;
    logic [RW-1:0]    trial;

    always_comb
    begin
        trial     = {rem_reg[RW-2:0], dvd_reg[DVD_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            q_next    = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                q_next   = 1'b1;
            end
            else
            begin
                rem_next = trial;
                q_next   = 1'b0;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.rem   = rem_reg[CNT_W-1:0];
    assign rsp.q_lsb = q_reg;

endmodule

### hw/rtl/pls_ctrl.sv
module pls_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pls_pkg::cfg_t                     cfg,
    input  pls_pkg::mode_wr_t                 mode_wr,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_func,
    input  logic [pls_pkg::EL_W-1:0]          in_elapsed,
    input  logic signed [pls_pkg::SEEK_W-1:0] in_seek,
    output logic                              res_valid,
    input  logic                              res_ready,
    output pls_pkg::res_t                     res,
    output pls_pkg::div_req_t                 div_req,
    input  pls_pkg::div_rsp_t                 div_rsp
);
    import pls_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_PLAN = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        KIND_SEEK,
        KIND_ADDLO,
        KIND_SUBHI,
        KIND_FOLD
    } kind_t;

    state_t                    st_reg, st_next;
    kind_t                     kind_reg, kind_next;
    logic [EL_W-1:0]           el_reg, el_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [STEP_W-1:0]  push_reg, push_next;
    logic [FRAC_BITS-1:0]      frac_reg, frac_next;
    logic [POS_W-1:0]          play_reg, play_next;
    logic signed [CNT_W-1:0]   prev_reg, prev_next;
    logic                      new_reg, new_next;
    logic                      dir_reg, dir_next;
    logic [POS_W-1:0]          lo_reg, lo_next, hi_reg, hi_next, span_reg, span_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      neg_reg, neg_next;

    logic [CNT_W-1:0]          cnt_c;
    logic [POS_W-1:0]          lastf_c, a_c, b_c;
    logic signed [PROD_W-1:0]  total;
    logic signed [PW-1:0]      play_s, push_s, mag_s, lo_s, hi_s, lastf_s;
    logic signed [PW-1:0]      p_wrap, p_pp, over_pp;
    logic [STEP_W-1:0]         mag;
    logic [SEEK_W-1:0]         seek_mag;
    logic [POS_W-1:0]          rem12, over12;
    logic                      fold_d;
    logic                      upd;

    always_comb
    begin
        // effective count and loop bounds
        cnt_c   = (cfg.total > CNT_W'(FRAMES_MAX)) ? CNT_W'(FRAMES_MAX) : cfg.total;
        lastf_c = POS_W'(cnt_c - 1'b1);
        a_c     = cfg.first[CNT_W-1] ? '0 : cfg.first[POS_W-1:0];
        b_c     = cfg.last[CNT_W-1] ? lastf_c : cfg.last[POS_W-1:0];
        if (a_c > lastf_c)
            a_c = lastf_c;
        if (b_c > lastf_c)
            b_c = lastf_c;

        seek_mag = in_seek[SEEK_W-1] ? (~in_seek + 1'b1) : in_seek;

        total   = prod_reg + $signed({{(PROD_W-FRAC_BITS){1'b0}}, frac_reg});
        mag     = push_reg[STEP_W-1] ? (~push_reg + 1'b1) : push_reg;
        play_s  = $signed({{(PW-POS_W){1'b0}}, play_reg});
        push_s  = $signed({{(PW-STEP_W){push_reg[STEP_W-1]}}, push_reg});
        mag_s   = $signed({{(PW-STEP_W){1'b0}}, mag});
        lo_s    = $signed({{(PW-POS_W){1'b0}}, lo_reg});
        hi_s    = $signed({{(PW-POS_W){1'b0}}, hi_reg});
        lastf_s = $signed({{(PW-POS_W){1'b0}}, POS_W'(cnt_reg - 1'b1)});
        p_wrap  = play_s + push_s;
        p_pp    = dir_reg ? (play_s + mag_s) : (play_s - mag_s);
        over_pp = (p_pp > hi_s) ? (p_pp - hi_s) : (lo_s - p_pp);

        rem12   = div_rsp.rem[POS_W-1:0];
        over12  = rem12 + 1'b1;
        fold_d  = dir_reg ^ div_rsp.q_lsb;

        st_next   = st_reg;
        kind_next = kind_reg;
        el_next   = el_reg;
        prod_next = prod_reg;
        push_next = push_reg;
        frac_next = frac_reg;
        play_next = play_reg;
        prev_next = prev_reg;
        new_next  = new_reg;
        dir_next  = dir_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        span_next = span_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        upd       = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = seek_mag;
        div_req.divisor  = cnt_c;

        in_ready  = (st_reg == ST_IDLE);
        res_valid = (st_reg == ST_OUT);

        if (mode_wr.pp_wr)
            dir_next = mode_wr.step_pos;

        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    el_next   = in_elapsed;
                    cnt_next  = cnt_c;
                    neg_next  = in_seek[SEEK_W-1];
                    lo_next   = (a_c < b_c) ? a_c : b_c;
                    hi_next   = (a_c < b_c) ? b_c : a_c;
                    span_next = ((a_c < b_c) ? b_c : a_c) - ((a_c < b_c) ? a_c : b_c);
                    if (in_func)
                    begin
                        if (cnt_c == '0)
                        begin
                            play_next = '0;
                            st_next   = ST_OUT;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            kind_next     = KIND_SEEK;
                            st_next       = ST_DIV;
                        end
                    end
                    else if (cnt_c == '0)
                        st_next = ST_OUT;
                    else
                        st_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = $signed({1'b0, el_reg}) * cfg.step;
                st_next   = ST_ADD;
            end
            ST_ADD:
            begin
                push_next = total[FRAC_BITS +: STEP_W];
                frac_next = (cfg.step == '0) ? '0 : total[FRAC_BITS-1:0];
                st_next   = ST_PLAN;
            end
            ST_PLAN:
            begin
                st_next = ST_OUT;
                if (push_reg == '0)
                    upd = 1'b1;
                else if (cfg.mode == MODE_CLAMP)
                begin
                    if (p_wrap < 0)
                        play_next = '0;
                    else if (p_wrap > lastf_s)
                        play_next = lastf_s[POS_W-1:0];
                    else
                        play_next = p_wrap[POS_W-1:0];
                    upd = 1'b1;
                end
                else if (span_reg == '0)
                begin
                    // narrow loop: hold position and history
                    st_next = ST_OUT;
                end
                else if (cfg.mode == MODE_WRAP)
                begin
                    div_req.divisor = {1'b0, span_reg};
                    if (p_wrap > hi_s)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(p_wrap - hi_s);
                        kind_next        = KIND_ADDLO;
                        st_next          = ST_DIV;
                    end
                    else if (p_wrap < lo_s)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(lo_s - p_wrap);
                        kind_next        = KIND_SUBHI;
                        st_next          = ST_DIV;
                    end
                    else
                    begin
                        play_next = p_wrap[POS_W-1:0];
                        upd       = 1'b1;
                    end
                end
                else if (cfg.mode == MODE_PINGPONG)
                begin
                    div_req.divisor = {1'b0, span_reg};
                    if (p_pp > hi_s || p_pp < lo_s)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(over_pp - 1);
                        kind_next        = KIND_FOLD;
                        st_next          = ST_DIV;
                    end
                    else
                    begin
                        play_next = p_pp[POS_W-1:0];
                        upd       = 1'b1;
                    end
                end
                else
                    upd = 1'b1;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    st_next = ST_OUT;
                    case (kind_reg)
                        KIND_SEEK:
                        begin
                            if (neg_reg && rem12 != '0)
                                play_next = POS_W'(cnt_reg - div_rsp.rem);
                            else
                                play_next = rem12;
                        end
                        KIND_ADDLO:
                        begin
                            play_next = lo_reg + rem12;
                            upd       = 1'b1;
                        end
                        KIND_SUBHI:
                        begin
                            play_next = hi_reg - rem12;
                            upd       = 1'b1;
                        end
                        KIND_FOLD:
                        begin
                            // odd number of extra folds flips the direction first
                            play_next = fold_d ? (hi_reg - over12) : (lo_reg + over12);
                            dir_next  = !fold_d;
                            upd       = 1'b1;
                        end
                        default:
                            play_next = play_reg;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                    st_next = ST_IDLE;
            end
            default:
                st_next = ST_IDLE;
        endcase

        if (upd)
        begin
            new_next  = (prev_reg != $signed({1'b0, play_next}));
            prev_next = $signed({1'b0, play_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            kind_reg <= KIND_SEEK;
            play_reg <= '0;
            prev_reg <= '1;
            frac_reg <= '0;
            dir_reg  <= 1'b1;
            new_reg  <= 1'b1;
        end
        else
        begin
            st_reg   <= st_next;
            kind_reg <= kind_next;
            play_reg <= play_next;
            prev_reg <= prev_next;
            frac_reg <= frac_next;
            dir_reg  <= dir_next;
            new_reg  <= new_next;
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg   <= el_next;
        prod_reg <= prod_next;
        push_reg <= push_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        span_reg <= span_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
    end

    assign res.frame     = play_reg;
    assign res.frame_new = new_reg;
    assign res.forward   = dir_reg;

    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("sequencer waits on an idle divider");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

    a_seek_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.done && kind_reg == KIND_SEEK) |-> (div_rsp.rem < cnt_reg))
        else $error("seek remainder not below frame count");

    a_loop_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.done && kind_reg != KIND_SEEK) |-> (div_rsp.rem < {1'b0, span_reg}))
        else $error("loop remainder not below span");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT && !res_ready) |=>
            (st_reg == ST_OUT && $stable(play_reg) && $stable(new_reg)))
        else $error("result changed while held");

endmodule

### tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RAND_PHASES     = 20;
    localparam int ITEMS_PER_PHASE = 95;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SEEK = 1'b1;

    localparam logic [1:0]       MODE_SPARE = 2'd3;
    localparam logic [IDX_W-1:0] REG_SPARE  = 3'd5;

    typedef struct {
        logic                     func;
        logic [EL_W-1:0]          elapsed;
        logic signed [SEEK_W-1:0] seek;
    } playhead_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] frame;
        logic             frame_new;
        logic             forward;
    } frame_word_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    playhead_cmd_t cmds_waiting[$];
    playhead_cmd_t next_cmd;
    frame_word_t   frames_due[$];

    logic s_took;
    bit   idle_on;
    int   feed_gap;
    int   sink_stall;
    int   failures;

    // shadow of the block's registers and playhead state
    logic [1:0]               cur_mode  = MODE_WRAP;
    logic signed [CNT_W-1:0]  cur_first = -1;
    logic signed [CNT_W-1:0]  cur_last  = -1;
    logic [CNT_W-1:0]         cur_total = '0;
    logic signed [STEP_W-1:0] cur_step  = 24'sd65536;
    longint                   head_pos      = 0;
    longint                   last_tick_pos = -1;
    logic [FRAC_BITS-1:0]     frac_kept     = '0;
    bit                       going_fwd     = 1'b1;
    bit                       moved_flag    = 1'b1;

    playhead_loop_stepper_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic longint frames_held();
        return (cur_total > FRAMES_MAX) ? longint'(FRAMES_MAX) : longint'(cur_total);
    endfunction

    function automatic void tick_playhead(logic [EL_W-1:0] elapsed);
        longint cnt, sum, push, p, a, b, lo, hi, span, mag, over, k;
        cnt  = frames_held();
        push = 0;
        // empty buffer: nothing changes, not even the fraction
        if (cnt == 0)
            return;
        if (cur_step != 0)
        begin
            sum       = longint'(elapsed) * longint'(cur_step) + longint'(frac_kept);
            frac_kept = sum[FRAC_BITS-1:0];
            push      = sum >>> FRAC_BITS;
        end
        else
        begin
            frac_kept = '0;
        end
        if (push != 0)
        begin
            if (cur_mode == MODE_CLAMP)
            begin
                p = head_pos + push;
                if (p < 0)
                    p = 0;
                if (p > cnt - 1)
                    p = cnt - 1;
                head_pos = p;
            end
            else
            begin
                a = (cur_first < 0) ? 0 : longint'(cur_first);
                b = (cur_last < 0) ? cnt - 1 : longint'(cur_last);
                if (a > cnt - 1)
                    a = cnt - 1;
                if (b > cnt - 1)
                    b = cnt - 1;
                lo   = (a < b) ? a : b;
                hi   = (a < b) ? b : a;
                span = hi - lo;
                // zero-width loop: hold position and leave the new-frame flag alone
                if (span <= 0)
                    return;
                if (cur_mode == MODE_WRAP)
                begin
                    p = head_pos + push;
                    if (p > hi)
                        p = lo + (p - hi) % span;
                    else if (p < lo)
                        p = hi - (lo - p) % span;
                    head_pos = p;
                end
                else if (cur_mode == MODE_PINGPONG)
                begin
                    mag = (push < 0) ? -push : push;
                    p   = going_fwd ? head_pos + mag : head_pos - mag;
                    if (p < lo || p > hi)
                    begin
                        over = (p > hi) ? p - hi : lo - p;
                        if (over > span)
                        begin
                            k     = (over - 1) / span;
                            over -= k * span;
                            if (k % 2 != 0)
                                going_fwd = !going_fwd;
                        end
                        p         = going_fwd ? hi - over : lo + over;
                        going_fwd = !going_fwd;
                    end
                    head_pos = p;
                end
            end
        end
        moved_flag    = (last_tick_pos != head_pos);
        last_tick_pos = head_pos;
    endfunction

    function automatic void seek_playhead(logic signed [SEEK_W-1:0] target);
        longint cnt, r;
        cnt = frames_held();
        r   = 0;
        if (cnt != 0)
        begin
            r = longint'(target) % cnt;
            if (r < 0)
                r += cnt;
        end
        head_pos = r;
    endfunction

    function automatic void take_reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_MODE:
            begin
                cur_mode = val[1:0];
                if (cur_mode == MODE_PINGPONG)
                    going_fwd = (cur_step > 0);
            end
            REG_FIRST: cur_first = val[CNT_W-1:0];
            REG_LAST:  cur_last  = val[CNT_W-1:0];
            REG_TOTAL: cur_total = val[CNT_W-1:0];
            REG_STEP:  cur_step  = val[STEP_W-1:0];
            default:   ;
        endcase
    endfunction

    function automatic void check_frame_word(logic [15:0] word);
        frame_word_t want;
        if (frames_due.size() == 0)
        begin
            $error("result word 0x%h with no item outstanding", word);
            failures++;
            return;
        end
        want = frames_due.pop_front();
        if (word[POS_W-1:0] !== want.frame)
        begin
            $error("frame: expected %0d, got %0d", want.frame, word[POS_W-1:0]);
            failures++;
        end
        if (word[12] !== want.frame_new)
        begin
            $error("frame_new: expected %0b, got %0b", want.frame_new, word[12]);
            failures++;
        end
        if (word[13] !== want.forward)
        begin
            $error("forward: expected %0b, got %0b", want.forward, word[13]);
            failures++;
        end
    endfunction

    // sample both sides and the config channel at the rising edge
    always @(posedge clk)
    begin
        s_took <= s_tvalid && s_tready;
        if (cfg_valid && cfg_ready)
            take_reg_write(cfg_index, cfg_data);
        if (m_tvalid && m_tready)
            check_frame_word(m_tdata);
        if (s_tvalid && s_tready)
        begin
            if (s_tuser == FUNC_TICK)
                tick_playhead(s_tdata[EL_W-1:0]);
            else
                seek_playhead(s_tdata[EL_W +: SEEK_W]);
            frames_due.push_back('{head_pos[POS_W-1:0], moved_flag, going_fwd});
        end
    end

    // hold the word until taken, then idle for the drawn gap
    always @(negedge clk)
    begin
        if (!s_tvalid || s_took)
        begin
            if (feed_gap > 0)
            begin
                s_tvalid <= 1'b0;
                feed_gap--;
            end
            else if (cmds_waiting.size() > 0)
            begin
                next_cmd = cmds_waiting.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_cmd.func;
                s_tdata  <= {next_cmd.seek, next_cmd.elapsed};
                feed_gap = pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            m_tready <= 1'b0;
            sink_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic queue_cmd(logic func, logic [EL_W-1:0] elapsed, int seek);
        playhead_cmd_t cmd;
        cmd.func    = func;
        cmd.elapsed = elapsed;
        cmd.seek    = SEEK_W'(seek);
        cmds_waiting.push_back(cmd);
    endtask

    // wait until every queued word is fed and every result is back, then let the block settle
    task automatic drain();
        while (cmds_waiting.size() != 0 || s_tvalid || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(logic [1:0] mode, int first, int last, int total, int step);
        write_reg(REG_TOTAL, total);
        write_reg(REG_FIRST, first);
        write_reg(REG_LAST, last);
        write_reg(REG_STEP, step);
        write_reg(REG_MODE, int'(mode));
    endtask

    function automatic int pick_loop_point(int total);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return -1;
        if (roll < 80)
            return $urandom_range(0, (total > 4095) ? 4095 : total);
        if (roll < 90)
            return $urandom_range(0, 4095);
        return -int'($urandom_range(2, 4096));
    endfunction

    initial
    begin
        int         roll;
        int         total;
        int         first;
        int         last;
        int         step;
        int         seek;
        logic [1:0] mode;
        logic [15:0] elapsed;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_took     = 1'b0;
        feed_gap   = 0;
        sink_stall = 0;
        failures   = 0;
        idle_on    = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty buffer straight out of reset
        queue_cmd(FUNC_TICK, 16'd100, 0);
        queue_cmd(FUNC_SEEK, 16'd0, 5);
        drain();

        load_setup(MODE_CLAMP, -1, -1, 10, 65536);
        queue_cmd(FUNC_TICK, 16'd3, 0);
        queue_cmd(FUNC_TICK, 16'hFFFF, 0);
        queue_cmd(FUNC_TICK, 16'd0, 0);
        queue_cmd(FUNC_SEEK, 16'd0, -1);
        queue_cmd(FUNC_SEEK, 16'hFFFF, -8388608);
        drain();

        // start point past the end, most negative step
        load_setup(MODE_WRAP, 4095, 2, 10, -8388608);
        queue_cmd(FUNC_TICK, 16'd1, 0);
        queue_cmd(FUNC_TICK, 16'hFFFF, 0);
        queue_cmd(FUNC_SEEK, 16'd0, 8388607);
        drain();

        // swapped loop points, largest step
        load_setup(MODE_PINGPONG, 8, 1, 9, 8388607);
        queue_cmd(FUNC_TICK, 16'd1, 0);
        queue_cmd(FUNC_TICK, 16'hFFFF, 0);
        queue_cmd(FUNC_TICK, 16'd3, 0);
        drain();

        // zero-width loop with half-frame step
        load_setup(MODE_WRAP, 5, 5, 10, 32768);
        queue_cmd(FUNC_TICK, 16'd3, 0);
        queue_cmd(FUNC_TICK, 16'd1, 0);
        drain();

        // unused mode and a count beyond the buffer size
        load_setup(MODE_SPARE, -1, -1, 8191, 65536);
        queue_cmd(FUNC_TICK, 16'd5, 0);
        queue_cmd(FUNC_SEEK, 16'd0, 5000);
        drain();

        // zero step in ping-pong mode runs backward
        load_setup(MODE_PINGPONG, -3, 4095, 40, 0);
        write_reg(REG_SPARE, $urandom());
        queue_cmd(FUNC_TICK, 16'd100, 0);
        drain();
        write_reg(REG_STEP, -65536);
        queue_cmd(FUNC_TICK, 16'd7, 0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);

            roll = $urandom_range(0, 99);
            if (roll < 60)
                total = $urandom_range(1, 24);
            else if (roll < 85)
                total = $urandom_range(25, 300);
            else if (roll < 93)
                total = $urandom_range(301, FRAMES_MAX);
            else if (roll < 97)
                total = $urandom_range(FRAMES_MAX + 1, 8191);
            else
                total = 0;
            first = pick_loop_point(total);
            last  = pick_loop_point(total);

            roll = $urandom_range(0, 99);
            if (roll < 30)
                step = $urandom_range(0, 4 * 65536);
            else if (roll < 55)
                step = $urandom_range(1, 65535);
            else if (roll < 70)
                step = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
            else if (roll < 80)
                step = 0;
            else if (roll < 90)
                step = 65536 * int'($urandom_range(1, 3));
            else
                step = $urandom_range(0, 1) ? 8388607 : -8388608;
            if (roll < 90 && $urandom_range(0, 1))
                step = -step;

            roll = $urandom_range(0, 99);
            if (roll < 35)
                mode = MODE_WRAP;
            else if (roll < 70)
                mode = MODE_PINGPONG;
            else if (roll < 92)
                mode = MODE_CLAMP;
            else
                mode = MODE_SPARE;

            if ($urandom_range(0, 3) != 0)
                write_reg(REG_TOTAL, total);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_FIRST, first);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_LAST, last);
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_SPARE, $urandom());
            // mode write latches direction from the step in place at that moment
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_STEP, step);
                write_reg(REG_MODE, int'(mode));
            end
            else
            begin
                write_reg(REG_MODE, int'(mode));
                write_reg(REG_STEP, step);
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    elapsed = EL_W'($urandom_range(0, 6));
                else if (roll < 90)
                    elapsed = EL_W'($urandom_range(0, 255));
                else
                    elapsed = EL_W'($urandom_range(0, 65535));

                if ($urandom_range(0, 1))
                begin
                    seek = $urandom_range(0, 2 * total + 2);
                    if ($urandom_range(0, 1))
                        seek = -seek;
                end
                else
                begin
                    seek = $urandom();
                end

                if ($urandom_range(0, 99) < 78)
                    queue_cmd(FUNC_TICK, elapsed, seek);
                else
                    queue_cmd(FUNC_SEEK, elapsed, seek);
            end
            drain();
        end

        if (failures == 0 && frames_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pls_pkg.sv
hw/rtl/pls_div.sv
hw/rtl/pls_ctrl.sv
hw/rtl/playhead_loop_stepper_top.sv
tb/sv/tb_top.sv
